// ----- rtl/core/serial_line_editor_top_defines.svh -----
// ----------------------------------------------------------------------------
// Serial line editor assertion macros
// Shared concurrent assertion forms for the line editor modules. They expect
// signals named clk and rst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_EDITOR_TOP_DEFINES_SVH
`define SERIAL_LINE_EDITOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial line editor package
// Character codes, status codes and the echo run descriptor shared by the
// line editor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

  localparam int LINE_MAX_DEF = 527;
  localparam int ACC_LEN_W    = 10;

  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NAK   = 8'h15;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_UPPER_U = 8'h55;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [1:0] STAT_EDIT   = 2'd0;
  localparam logic [1:0] STAT_ACCEPT = 2'd1;
  localparam logic [1:0] STAT_CANCEL = 2'd2;

  typedef enum logic [1:0] {
    RUN_CHAR,
    RUN_ACCEPT,
    RUN_RUBOUT,
    RUN_CANCEL
  } run_kind_t;

  // One echo run: the bytes caused by one input transaction.
  typedef struct packed {
    run_kind_t              kind;
    logic [7:0]             ch;
    logic [ACC_LEN_W-1:0]   len;
  } run_t;

endpackage

// ----- rtl/core/sle_edit.sv -----
// ----------------------------------------------------------------------------
// Serial line editor: edit stage
// Holds the received byte, classifies it, updates the line length and the
// line store, and hands any echo run that the byte causes to the echo stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_line_editor_top_defines.svh"

module sle_edit #(
  parameter int LINE_MAX = sle_pkg::LINE_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_rx_byte,
  output logic          run_valid,
  input  logic          run_ready,
  output sle_pkg::run_t run
);

  localparam int LEN_W = $clog2(LINE_MAX + 1);
  localparam int DEPTH = LINE_MAX + 1;

  logic             in_full_r;
  logic [7:0]       in_byte_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic [7:0]       line_store_r [DEPTH];

  logic is_print, is_eol, is_rub, is_cancel;
  logic room, not_empty, consume;
  logic store_we;
  logic [7:0] store_data;
  logic [LEN_W+sle_pkg::ACC_LEN_W-1:0] len_ext;

  assign is_print  = (in_byte_r >= sle_pkg::CH_SPACE) && (in_byte_r <= sle_pkg::CH_TILDE);
  assign is_eol    = (in_byte_r == sle_pkg::CH_CR) || (in_byte_r == sle_pkg::CH_LF);
  assign is_rub    = (in_byte_r == sle_pkg::CH_BS) || (in_byte_r == sle_pkg::CH_DEL);
  assign is_cancel = (in_byte_r == sle_pkg::CH_ETX) || (in_byte_r == sle_pkg::CH_NAK);

  assign room      = len_r < LEN_W'(LINE_MAX);
  assign not_empty = len_r != '0;

  // Bytes that echo nothing leave the input register without waiting.
  assign run_valid = in_full_r &&
                     ((is_print && room) || is_eol || (is_rub && not_empty) || is_cancel);
  assign consume   = in_full_r && (!run_valid || run_ready);
  assign in_ready  = !in_full_r || consume;

  // The reported length is the low bits of the line length.
  assign len_ext = {{sle_pkg::ACC_LEN_W{1'b0}}, len_r};

  always_comb begin
    run.ch  = in_byte_r;
    run.len = len_ext[sle_pkg::ACC_LEN_W-1:0];
    if (is_eol) begin
      run.kind = sle_pkg::RUN_ACCEPT;
    end else if (is_rub) begin
      run.kind = sle_pkg::RUN_RUBOUT;
    end else if (is_cancel) begin
      run.kind = sle_pkg::RUN_CANCEL;
    end else begin
      run.kind = sle_pkg::RUN_CHAR;
    end
  end

  always_comb begin
    len_nxt    = len_r;
    store_we   = 1'b0;
    store_data = in_byte_r;
    if (consume && run_valid) begin
      if (is_print) begin
        len_nxt  = len_r + LEN_W'(1);
        store_we = 1'b1;
      end else if (is_eol) begin
        len_nxt    = '0;
        store_we   = 1'b1;
        store_data = 8'h00;
      end else if (is_rub) begin
        len_nxt = len_r - LEN_W'(1);
      end else begin
        len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      len_r     <= '0;
    end else begin
      len_r <= len_nxt;
      if (in_valid && in_ready) begin
        in_full_r <= 1'b1;
      end else if (consume) begin
        in_full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      line_store_r[len_r] <= store_data;
    end
  end

  `SLE_ASSERT_SAME(a_len_in_range, 1'b1, len_r <= LEN_W'(LINE_MAX), "line length over limit")
  `SLE_ASSERT_NEXT(a_eol_clears, consume && run_valid && (is_eol || is_cancel), len_r == '0, "line length not cleared after end of line")

endmodule

// ----- rtl/core/sle_echo.sv -----
// ----------------------------------------------------------------------------
// Serial line editor: echo stage
// Holds one echo run and sends its bytes one per cycle while the receiver is
// ready, with the line status and accepted length on the final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_line_editor_top_defines.svh"

module sle_echo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            run_valid,
  output logic                            run_ready,
  input  sle_pkg::run_t                   run,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_echo_byte,
  output logic                            out_last_of_run,
  output logic [1:0]                      out_line_status,
  output logic [sle_pkg::ACC_LEN_W-1:0]   out_accepted_length
);

  logic          busy_r;
  logic [1:0]    idx_r;
  sle_pkg::run_t run_r;
  logic          last;
  logic          load;

  assign last = (run_r.kind == sle_pkg::RUN_CHAR) || (run_r.kind == sle_pkg::RUN_ACCEPT) ||
                (idx_r == 2'd2);

  assign run_ready = !busy_r || (out_ready && last);
  assign load      = run_valid && run_ready;

  assign out_valid       = busy_r;
  assign out_last_of_run = last;

  always_comb begin
    out_echo_byte       = run_r.ch;
    out_line_status     = sle_pkg::STAT_EDIT;
    out_accepted_length = '0;
    case (run_r.kind)
      sle_pkg::RUN_CHAR: begin
        out_echo_byte = run_r.ch;
      end
      sle_pkg::RUN_ACCEPT: begin
        out_echo_byte       = sle_pkg::CH_LF;
        out_line_status     = sle_pkg::STAT_ACCEPT;
        out_accepted_length = run_r.len;
      end
      sle_pkg::RUN_RUBOUT: begin
        out_echo_byte = (idx_r == 2'd1) ? sle_pkg::CH_SPACE : sle_pkg::CH_BS;
      end
      sle_pkg::RUN_CANCEL: begin
        if (idx_r == 2'd0) begin
          out_echo_byte = sle_pkg::CH_CARET;
        end else if (idx_r == 2'd1) begin
          out_echo_byte = (run_r.ch == sle_pkg::CH_ETX) ? sle_pkg::CH_UPPER_C
                                                        : sle_pkg::CH_UPPER_U;
        end else begin
          out_echo_byte   = sle_pkg::CH_LF;
          out_line_status = sle_pkg::STAT_CANCEL;
        end
      end
      default: begin
        out_echo_byte = run_r.ch;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (busy_r && out_ready) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run;
    end
  end

  `SLE_ASSERT_SAME(a_status_on_last, busy_r && (out_line_status != sle_pkg::STAT_EDIT), last, "line status before final echo byte")
  `SLE_ASSERT_SAME(a_len_on_accept, busy_r && (out_accepted_length != '0), out_line_status == sle_pkg::STAT_ACCEPT, "length reported without accept")

endmodule

// ----- rtl/core/serial_line_editor_top.sv -----
// An accepted byte passes from the edit stage input register into the echo stage run
// register, which then drives its first echo byte.
// Throughput: one input transaction per cycle for bytes with at most one echo byte
// while the receiver is ready; rubout and cancel hold the echo register until all three
// of their echo bytes are taken. Ignored and dropped bytes leave the input register without waiting, with no echo.
// Reset (rst_n low, synchronous) empties both registers and sets the line length to
// zero; the line store is not cleared and holds unknown data until written.
// ----------------------------------------------------------------------------
// Serial line editor top level
// Edits a command line from received serial bytes and echoes to the terminal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_line_editor_top #(
  parameter int LINE_MAX = sle_pkg::LINE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_echo_byte,
  output logic                            out_last_of_run,
  output logic [1:0]                      out_line_status,
  output logic [sle_pkg::ACC_LEN_W-1:0]   out_accepted_length
);

  logic          run_valid;
  logic          run_ready;
  sle_pkg::run_t run;

  sle_edit #(
    .LINE_MAX (LINE_MAX)
  ) u_edit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .run_valid  (run_valid),
    .run_ready  (run_ready),
    .run        (run)
  );

  sle_echo u_echo (
    .clk                 (clk),
    .rst_n               (rst_n),
    .run_valid           (run_valid),
    .run_ready           (run_ready),
    .run                 (run),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_echo_byte       (out_echo_byte),
    .out_last_of_run     (out_last_of_run),
    .out_line_status     (out_line_status),
    .out_accepted_length (out_accepted_length)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line editor testbench
// Feeds received bytes into the line editor and checks every echo byte, the
// end-of-run flag, the line status and the accepted length against a
// behavioral model of the edit line. The stimulus covers all byte classes,
// an empty line, and runs under three handshake idling patterns.
// ----------------------------------------------------------------------------

module tb;

  localparam int LINE_LIMIT  = sle_pkg::LINE_MAX_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 145;

  typedef struct packed {
    logic [7:0]                    ch;
    logic                          last;
    logic [1:0]                    status;
    logic [sle_pkg::ACC_LEN_W-1:0] len;
  } echo_t;

  class echo_scoreboard;
    echo_t echo_expected[$];
    int    line_len;
    int    err_count;

    function new();
      line_len  = 0;
      err_count = 0;
    endfunction

    function void push_echo(logic [7:0] ch, logic last, logic [1:0] status,
                            logic [sle_pkg::ACC_LEN_W-1:0] len);
      echo_t e;
      e.ch     = ch;
      e.last   = last;
      e.status = status;
      e.len    = len;
      echo_expected.push_back(e);
    endfunction

    // Updates the line state for one accepted byte and queues its echo run.
    // Returns the number of echo bytes that the byte causes.
    function int note_rx_byte(logic [7:0] b);
      if (b >= sle_pkg::CH_SPACE && b <= sle_pkg::CH_TILDE) begin
        if (line_len < LINE_LIMIT) begin
          line_len++;
          push_echo(b, 1'b1, sle_pkg::STAT_EDIT, '0);
          return 1;
        end
        return 0;
      end
      if (b == sle_pkg::CH_CR || b == sle_pkg::CH_LF) begin
        push_echo(sle_pkg::CH_LF, 1'b1, sle_pkg::STAT_ACCEPT,
                  line_len[sle_pkg::ACC_LEN_W-1:0]);
        line_len = 0;
        return 1;
      end
      if (b == sle_pkg::CH_BS || b == sle_pkg::CH_DEL) begin
        if (line_len == 0) return 0;
        line_len--;
        push_echo(sle_pkg::CH_BS, 1'b0, sle_pkg::STAT_EDIT, '0);
        push_echo(sle_pkg::CH_SPACE, 1'b0, sle_pkg::STAT_EDIT, '0);
        push_echo(sle_pkg::CH_BS, 1'b1, sle_pkg::STAT_EDIT, '0);
        return 3;
      end
      if (b == sle_pkg::CH_ETX || b == sle_pkg::CH_NAK) begin
        line_len = 0;
        push_echo(sle_pkg::CH_CARET, 1'b0, sle_pkg::STAT_EDIT, '0);
        push_echo((b == sle_pkg::CH_ETX) ? sle_pkg::CH_UPPER_C : sle_pkg::CH_UPPER_U,
                  1'b0, sle_pkg::STAT_EDIT, '0);
        push_echo(sle_pkg::CH_LF, 1'b1, sle_pkg::STAT_CANCEL, '0);
        return 3;
      end
      return 0;
    endfunction

    task report(string what, int got, int want);
      $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      err_count++;
    endtask

    task check_echo(logic [7:0] ch, logic last, logic [1:0] status,
                    logic [sle_pkg::ACC_LEN_W-1:0] len);
      echo_t e;
      if (echo_expected.size() == 0) begin
        report("echo byte with nothing pending", ch, 0);
        return;
      end
      e = echo_expected.pop_front();
      if (ch !== e.ch) report("echo_byte", ch, e.ch);
      if (last !== e.last) report("last_of_run", last, e.last);
      if (status !== e.status) report("line_status", status, e.status);
      if (len !== e.len) report("accepted_length", len, e.len);
    endtask

    function int pending();
      return echo_expected.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_rx_byte;
  logic                          out_valid;
  logic                          out_ready;
  logic [7:0]                    out_echo_byte;
  logic                          out_last_of_run;
  logic [1:0]                    out_line_status;
  logic [sle_pkg::ACC_LEN_W-1:0] out_accepted_length;

  echo_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int sent_items;
  int cycle_count;

  serial_line_editor_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_echo_byte       (out_echo_byte),
    .out_last_of_run     (out_last_of_run),
    .out_line_status     (out_line_status),
    .out_accepted_length (out_accepted_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_echo(out_echo_byte, out_last_of_run, out_line_status, out_accepted_length);
  end

  // Receiver side: ready is redrawn on every falling edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  // Valid stays high on return so back-to-back bytes need no gap.
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    void'(sb.note_rx_byte(b));
    sent_items++;
    @(negedge clk);
  endtask

  // One edited line with random content, mostly short, ended by accept or
  // cancel, or left open so the next line continues it.
  task automatic send_line();
    int n;
    int k;
    int r;
    logic [7:0] b;
    n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 10) b = ($urandom_range(1) != 0) ? sle_pkg::CH_BS : sle_pkg::CH_DEL;
      else if (r < 15) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(int'(sle_pkg::CH_TILDE), int'(sle_pkg::CH_SPACE)));
      send_byte(b);
    end
    r = $urandom_range(99);
    if (r < 35) send_byte(sle_pkg::CH_CR);
    else if (r < 70) send_byte(sle_pkg::CH_LF);
    else if (r < 80) send_byte(sle_pkg::CH_ETX);
    else if (r < 90) send_byte(sle_pkg::CH_NAK);
  endtask

  task automatic send_noise();
    int n;
    int k;
    n = $urandom_range(4, 1);
    for (k = 0; k < n; k++) send_byte(8'($urandom_range(255)));
  endtask

  task automatic run_random(int items);
    int target;
    target = sent_items + items;
    while (sent_items < target) begin
      if ($urandom_range(9) == 0) send_noise();
      else send_line();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_rx_byte    = 8'h00;
    send_idle_pct = 13;
    recv_idle_pct = 53;
    sent_items    = 0;
    cycle_count   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty accept, rubouts on an empty line, ignored bytes at the
    // code extremes, printable extremes, both rubout codes, both cancels.
    send_byte(sle_pkg::CH_CR);
    send_byte(sle_pkg::CH_BS);
    send_byte(sle_pkg::CH_DEL);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h1F);
    send_byte(sle_pkg::CH_SPACE);
    send_byte(sle_pkg::CH_TILDE);
    send_byte(8'h61);
    send_byte(sle_pkg::CH_BS);
    send_byte(sle_pkg::CH_DEL);
    send_byte(8'h5A);
    send_byte(sle_pkg::CH_LF);
    send_byte(8'h78);
    send_byte(sle_pkg::CH_ETX);
    send_byte(8'h79);
    send_byte(sle_pkg::CH_NAK);
    send_byte(sle_pkg::CH_LF);
    send_byte(sle_pkg::CH_DEL);
    send_byte(8'h71);
    send_byte(sle_pkg::CH_CR);

    run_random(PHASE_ITEMS);

    send_idle_pct = 53;
    recv_idle_pct = 13;
    run_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);

    in_valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- serial_line_editor_top.f -----
+incdir+rtl/core
rtl/core/sle_pkg.sv
rtl/core/sle_edit.sv
rtl/core/sle_echo.sv
rtl/core/serial_line_editor_top.sv
sim/tb.sv
